>>> src/ptom_pkg.sv
package ptom_pkg;

  localparam int BOOK_DEPTH = 16;
  localparam int IDX_W      = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
  localparam int MAX_FILLS  = 31;
  localparam int FILLS_W    = 5;

  localparam logic [1:0] CMD_ADD_BUY  = 2'd0;
  localparam logic [1:0] CMD_ADD_SELL = 2'd1;
  localparam logic [1:0] CMD_MATCH    = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  typedef struct packed {
    logic [15:0] trader;
    logic [31:0] price;
    logic [30:0] qty;
  } entry_t;

  typedef struct packed {
    logic             ins;
    logic [CNT_W-1:0] ins_pos;
    entry_t           ins_entry;
    logic             pop;
    logic             hq_wr;
    logic [30:0]      hq_val;
  } book_ctl_t;

endpackage

>>> src/price_time_order_matcher.sv
// Channel | Direction | tdata (low bit up)                          | tuser   | tlast
// in_     | slave     | trader, price, quantity                     | command | -
// out_    | master    | buy_trader, sell_trader, fill_quantity,     | status  | is_last
//         |           | buy_price, sell_price                       |         |
// An add checks quantity and book space, scans the resting orders ahead of it, then
// inserts. A match tests the cross, compares and subtracts quantities per fill, all on
// the single shared subtractor for the price scan, cross test and both quantity steps.
// rst_n is synchronous and clears the sequencer, book counts and output valid.
// in_tready is high only while idle; a stalled result holds the sequencer.
module price_time_order_matcher (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [79:0]   in_tdata,   // trader[15:0], price[47:16], quantity[78:48]
  input  logic [1:0]    in_tuser,   // command[1:0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // buy_trader[15:0], sell_trader[31:16],
                                    // fill_quantity[62:32], buy_price[94:63],
                                    // sell_price[126:95]
  output logic [2:0]    out_tuser,  // status[2:0]
  output logic          out_tlast   // is_last
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ADD    = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_INSERT = 8'b0000_1000,
    S_CROSS  = 8'b0001_0000,
    S_QCMP   = 8'b0010_0000,
    S_QSUB   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [1:0]                   cmd_r, cmd_nxt;
  ptom_pkg::entry_t             item_r, item_nxt;
  logic [ptom_pkg::CNT_W-1:0]   pos_r, pos_nxt;
  logic [ptom_pkg::FILLS_W-1:0] fills_r, fills_nxt;
  logic [30:0]                  fq_r, fq_nxt;
  logic                         bsmall_r, bsmall_nxt;
  logic                         eq_r, eq_nxt;

  logic                         ov_r, ov_nxt;
  logic [127:0]                 od_r, od_nxt;
  logic [2:0]                   ou_r, ou_nxt;
  logic                         ol_r, ol_nxt;

  ptom_pkg::book_ctl_t          bctl, sctl;
  ptom_pkg::entry_t             brd, srd, bhead, shead;
  logic [ptom_pkg::CNT_W-1:0]   bcnt, scnt;
  logic [31:0]                  alu_a, alu_b, alu_diff;
  logic                         alu_borrow;
  logic                         is_buy, slot_free, in_acc;
  logic [ptom_pkg::CNT_W-1:0]   cur_cnt;
  ptom_pkg::entry_t             cur_rd;

  ptom_book u_buy (.clk, .rst_n, .ctl(bctl), .rd_idx(pos_r[ptom_pkg::IDX_W-1:0]),
                   .rd_entry(brd), .head(bhead), .count(bcnt));
  ptom_book u_sell (.clk, .rst_n, .ctl(sctl), .rd_idx(pos_r[ptom_pkg::IDX_W-1:0]),
                    .rd_entry(srd), .head(shead), .count(scnt));
  ptom_alu u_alu (.a(alu_a), .b(alu_b), .diff(alu_diff), .borrow(alu_borrow));

  assign is_buy    = (cmd_r == ptom_pkg::CMD_ADD_BUY);
  assign cur_cnt   = is_buy ? bcnt : scnt;
  assign cur_rd    = is_buy ? brd : srd;
  assign slot_free = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Steer the shared subtractor by state
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_SCAN: begin
        if (is_buy) begin
          alu_a = cur_rd.price;
          alu_b = item_r.price;
        end else begin
          alu_a = item_r.price;
          alu_b = cur_rd.price;
        end
      end
      S_CROSS: begin
        alu_a = bhead.price;
        alu_b = shead.price;
      end
      S_QCMP: begin
        alu_a = {1'b0, bhead.qty};
        alu_b = {1'b0, shead.qty};
      end
      S_QSUB: begin
        alu_a = bsmall_r ? {1'b0, shead.qty} : {1'b0, bhead.qty};
        alu_b = {1'b0, fq_r};
      end
      S_IDLE, S_ADD, S_INSERT, S_DONE: begin
        alu_a = '0;
      end
      default: alu_a = '0;
    endcase
  end

  // Sequence one transaction at a time
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    item_nxt   = item_r;
    pos_nxt    = pos_r;
    fills_nxt  = fills_r;
    fq_nxt     = fq_r;
    bsmall_nxt = bsmall_r;
    eq_nxt     = eq_r;
    ov_nxt     = ov_r && !out_tready;
    od_nxt     = od_r;
    ou_nxt     = ou_r;
    ol_nxt     = ol_r;
    bctl       = '0;
    sctl       = '0;
    bctl.ins_entry = item_r;
    sctl.ins_entry = item_r;
    bctl.ins_pos   = pos_r;
    sctl.ins_pos   = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt         = in_tuser;
          item_nxt.trader = in_tdata[15:0];
          item_nxt.price  = in_tdata[47:16];
          item_nxt.qty    = in_tdata[78:48];
          fills_nxt       = '0;
          pos_nxt         = '0;
          priority if (in_tuser == ptom_pkg::CMD_MATCH) begin
            state_nxt = S_CROSS;
          end else if (in_tuser == ptom_pkg::CMD_ADD_BUY ||
                       in_tuser == ptom_pkg::CMD_ADD_SELL) begin
            state_nxt = S_ADD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ADD: begin
        if (item_r.qty == '0) begin
          if (slot_free) begin
            {ov_nxt, od_nxt, ou_nxt, ol_nxt} = {1'b1, 128'd0, ptom_pkg::ST_ZERO, 1'b1};
            state_nxt = S_IDLE;
          end
        end else if (cur_cnt >= ptom_pkg::CNT_W'(ptom_pkg::BOOK_DEPTH)) begin
          if (slot_free) begin
            {ov_nxt, od_nxt, ou_nxt, ol_nxt} = {1'b1, 128'd0, ptom_pkg::ST_FULL, 1'b1};
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pos_r == cur_cnt || alu_borrow) begin
          state_nxt = S_INSERT;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_INSERT: begin
        if (slot_free) begin
          bctl.ins = is_buy;
          sctl.ins = !is_buy;
          {ov_nxt, od_nxt, ou_nxt, ol_nxt} = {1'b1, 128'd0, ptom_pkg::ST_ADDED, 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_CROSS: begin
        if (fills_r == ptom_pkg::FILLS_W'(ptom_pkg::MAX_FILLS) ||
            bcnt == '0 || scnt == '0 || alu_borrow) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_QCMP;
        end
      end
      S_QCMP: begin
        bsmall_nxt = alu_borrow;
        eq_nxt     = (alu_diff == '0);
        fq_nxt     = alu_borrow ? bhead.qty : shead.qty;
        state_nxt  = S_QSUB;
      end
      S_QSUB: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          od_nxt = {1'b0, shead.price, bhead.price, fq_r, shead.trader, bhead.trader};
          ou_nxt = ptom_pkg::ST_FILL;
          ol_nxt = 1'b0;
          fills_nxt = fills_r + 1'b1;
          if (eq_r) begin
            bctl.pop = 1'b1;
            sctl.pop = 1'b1;
          end else if (bsmall_r) begin
            bctl.pop    = 1'b1;
            sctl.hq_wr  = 1'b1;
            sctl.hq_val = alu_diff[30:0];
          end else begin
            sctl.pop    = 1'b1;
            bctl.hq_wr  = 1'b1;
            bctl.hq_val = alu_diff[30:0];
          end
          state_nxt = S_CROSS;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          {ov_nxt, od_nxt, ou_nxt, ol_nxt} = {1'b1, 128'd0, ptom_pkg::ST_DONE, 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    item_r   <= item_nxt;
    pos_r    <= pos_nxt;
    fills_r  <= fills_nxt;
    fq_r     <= fq_nxt;
    bsmall_r <= bsmall_nxt;
    eq_r     <= eq_nxt;
    od_r     <= od_nxt;
    ou_r     <= ou_nxt;
    ol_r     <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

`ifndef ASSERT_OFF
  a_fill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ptom_pkg::ST_FILL |-> !out_tlast)
    else $error("fill marked last");
  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ptom_pkg::ST_FILL |-> out_tdata[62:32] != '0)
    else $error("zero fill quantity");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser != ptom_pkg::CMD_UNUSED |=> !in_tready)
    else $error("ready while command in progress");
`endif

endmodule

>>> src/ptom_alu.sv
module ptom_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] diff,
  output logic        borrow
);

  // Subtract with borrow out; borrow set means a < b
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

>>> src/ptom_book.sv
module ptom_book (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ptom_pkg::book_ctl_t        ctl,
  input  logic [ptom_pkg::IDX_W-1:0] rd_idx,
  output ptom_pkg::entry_t           rd_entry,
  output ptom_pkg::entry_t           head,
  output logic [ptom_pkg::CNT_W-1:0] count
);

  ptom_pkg::entry_t                 ent_r   [ptom_pkg::BOOK_DEPTH];
  ptom_pkg::entry_t                 ent_nxt [ptom_pkg::BOOK_DEPTH];
  logic [ptom_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;

  // Shift entries open on insert, close on pop, patch head quantity
  always_comb begin
    for (int i = 0; i < ptom_pkg::BOOK_DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
      if (ctl.ins) begin
        if (ptom_pkg::CNT_W'(i) == ctl.ins_pos) begin
          ent_nxt[i] = ctl.ins_entry;
        end else if (i > 0 && ptom_pkg::CNT_W'(i) > ctl.ins_pos) begin
          ent_nxt[i] = ent_r[(i > 0) ? i - 1 : 0];
        end
      end else if (ctl.pop) begin
        if (i < ptom_pkg::BOOK_DEPTH - 1) begin
          ent_nxt[i] = ent_r[(i < ptom_pkg::BOOK_DEPTH - 1) ? i + 1 : i];
        end
      end else if (ctl.hq_wr && i == 0) begin
        ent_nxt[i].qty = ctl.hq_val;
      end
    end
    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ptom_pkg::BOOK_DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign rd_entry = ent_r[rd_idx];
  assign head     = ent_r[0];
  assign count    = cnt_r;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ptom_pkg::CNT_W'(ptom_pkg::BOOK_DEPTH))
    else $error("book count beyond depth");
  a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |-> cnt_r < ptom_pkg::CNT_W'(ptom_pkg::BOOK_DEPTH))
    else $error("insert into full book");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> cnt_r != '0)
    else $error("pop from empty book");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] trader;
    logic [31:0] price;
    logic [30:0] qty;
  } order_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] buy_trader;
    logic [15:0] sell_trader;
    logic [30:0] fill_qty;
    logic [31:0] buy_price;
    logic [31:0] sell_price;
    logic        last;
  } trade_report_t;

  localparam int MAX_CYCLES = 400000;
  localparam int LONG_HOLD  = 300;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [79:0]  in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  order_cmd_t        pending_cmds[$];
  trade_report_t     expected_reports[$];
  ptom_pkg::entry_t  bids[$];
  ptom_pkg::entry_t  asks[$];
  int                errors = 0;
  int                cycle_count = 0;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_cycles = 0;
  bit                hold_req = 1'b0;
  bit                hold_taken = 1'b0;

  price_time_order_matcher u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predict the reports caused by one accepted command
  function automatic void predict_reports(order_cmd_t c);
    trade_report_t    r;
    ptom_pkg::entry_t e;
    int               pos;
    logic [30:0]      f;
    int               fills;
    r = '0;
    r.last = 1'b1;
    if (c.cmd == ptom_pkg::CMD_UNUSED) return;
    if (c.cmd == ptom_pkg::CMD_MATCH) begin
      fills = 0;
      while (fills < ptom_pkg::MAX_FILLS && bids.size() > 0 && asks.size() > 0 &&
             asks[0].price <= bids[0].price) begin
        f = (bids[0].qty < asks[0].qty) ? bids[0].qty : asks[0].qty;
        expected_reports.push_back('{ptom_pkg::ST_FILL, bids[0].trader, asks[0].trader,
                                     f, bids[0].price, asks[0].price, 1'b0});
        bids[0].qty -= f;
        asks[0].qty -= f;
        if (bids[0].qty == 0) void'(bids.pop_front());
        if (asks[0].qty == 0) void'(asks.pop_front());
        fills++;
      end
      r.status = ptom_pkg::ST_DONE;
    end else if (c.qty == 0) begin
      r.status = ptom_pkg::ST_ZERO;
    end else if ((c.cmd == ptom_pkg::CMD_ADD_BUY ? bids.size() : asks.size()) >=
                 ptom_pkg::BOOK_DEPTH) begin
      r.status = ptom_pkg::ST_FULL;
    end else begin
      e = '{c.trader, c.price, c.qty};
      pos = 0;
      if (c.cmd == ptom_pkg::CMD_ADD_BUY) begin
        while (pos < bids.size() && bids[pos].price >= c.price) pos++;
        bids.insert(pos, e);
      end else begin
        while (pos < asks.size() && asks[pos].price <= c.price) pos++;
        asks.insert(pos, e);
      end
      r.status = ptom_pkg::ST_ADDED;
    end
    expected_reports.push_back(r);
  endfunction

  // Drive commands from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= ptom_pkg::CMD_ADD_BUY;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_reports({in_tuser, in_tdata[15:0], in_tdata[47:16],
                                      in_tdata[78:48]});
      if (pending_cmds.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_cmds[0].cmd;
        in_tdata  <= {1'b0, pending_cmds[0].qty, pending_cmds[0].price,
                      pending_cmds[0].trader};
        void'(pending_cmds.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Count down one long receiver hold-off once requested
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_cycles <= LONG_HOLD;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Check reports and randomise backpressure
  always @(posedge clk) begin
    trade_report_t got;
    trade_report_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[62:32],
                out_tdata[94:63], out_tdata[126:95], out_tlast};
        if (expected_reports.size() == 0) begin
          $error("unexpected report status=%0d", got.status);
          errors++;
        end else begin
          exp_r = expected_reports.pop_front();
          if (got.status != exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++; end
          if (got.buy_trader != exp_r.buy_trader) begin
            $error("buy_trader exp %0d got %0d", exp_r.buy_trader, got.buy_trader);
            errors++; end
          if (got.sell_trader != exp_r.sell_trader) begin
            $error("sell_trader exp %0d got %0d", exp_r.sell_trader, got.sell_trader);
            errors++; end
          if (got.fill_qty != exp_r.fill_qty) begin
            $error("fill_quantity exp %0d got %0d", exp_r.fill_qty, got.fill_qty);
            errors++; end
          if (got.buy_price != exp_r.buy_price) begin
            $error("buy_price exp %0d got %0d", exp_r.buy_price, got.buy_price);
            errors++; end
          if (got.sell_price != exp_r.sell_price) begin
            $error("sell_price exp %0d got %0d", exp_r.sell_price, got.sell_price);
            errors++; end
          if (got.last != exp_r.last) begin
            $error("is_last exp %0d got %0d", exp_r.last, got.last); errors++; end
        end
      end
      if (hold_cycles > 0 || (hold_req && !hold_taken)) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic order_cmd_t rand_order();
    order_cmd_t c;
    int         r;
    r = $urandom_range(99, 0);
    c.cmd    = (r < 40) ? ptom_pkg::CMD_ADD_BUY : (r < 80) ? ptom_pkg::CMD_ADD_SELL :
               (r < 97) ? ptom_pkg::CMD_MATCH : ptom_pkg::CMD_UNUSED;
    c.trader = 16'($urandom);
    // Cluster prices so books cross and ties occur; sometimes full range
    c.price  = ($urandom_range(9, 0) == 0) ? $urandom : 32'd1000 + $urandom_range(20, 0);
    case ($urandom_range(9, 0))
      0:       c.qty = 31'd0;
      1:       c.qty = 31'($urandom);
      default: c.qty = 31'($urandom_range(50, 1));
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_tvalid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int i;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty match, zero quantity, extremes, ties, unused command
    pending_cmds.push_back('{ptom_pkg::CMD_MATCH, 16'd0, 32'd0, 31'd0});
    pending_cmds.push_back('{ptom_pkg::CMD_ADD_BUY, 16'hFFFF, 32'hFFFF_FFFF, 31'd0});
    pending_cmds.push_back('{ptom_pkg::CMD_ADD_SELL, 16'd1, 32'd0, 31'd0});
    pending_cmds.push_back('{ptom_pkg::CMD_ADD_BUY, 16'hFFFF, 32'hFFFF_FFFF,
                             31'h7FFF_FFFF});
    pending_cmds.push_back('{ptom_pkg::CMD_ADD_BUY, 16'd2, 32'd100, 31'd5});
    pending_cmds.push_back('{ptom_pkg::CMD_ADD_BUY, 16'd3, 32'd100, 31'd7});
    pending_cmds.push_back('{ptom_pkg::CMD_ADD_SELL, 16'd4, 32'd0, 31'h7FFF_FFFF});
    pending_cmds.push_back('{ptom_pkg::CMD_ADD_SELL, 16'd5, 32'd100, 31'd3});
    pending_cmds.push_back('{ptom_pkg::CMD_ADD_SELL, 16'd6, 32'd100, 31'd4});
    pending_cmds.push_back('{ptom_pkg::CMD_UNUSED, 16'hAAAA, 32'h5555_5555,
                             31'h2AAA_AAAA});
    pending_cmds.push_back('{ptom_pkg::CMD_MATCH, 16'h5555, 32'hAAAA_AAAA,
                             31'h5555_5555});
    pending_cmds.push_back('{ptom_pkg::CMD_MATCH, 16'd0, 32'd0, 31'd0});
    for (i = 0; i < 17; i++)
      pending_cmds.push_back('{ptom_pkg::CMD_ADD_BUY, 16'(i), 32'(10 + i % 3),
                               31'(i + 1)});
    wait_drained();

    // Random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 46 : 27) : 0;
      recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 27 : 0;
      if (ph == 2) hold_req = 1'b1;
      for (i = 0; i < 47; i++) pending_cmds.push_back(rand_order());
      pending_cmds.push_back('{ptom_pkg::CMD_MATCH, 16'd0, 32'd0, 31'd0});
      wait_drained();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
